// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== hw/rtl/mfrq_pkg.sv =====
// ---------------------------------------------------------------------------
// Request queue package
// Widths, level codes, register indexes and shared types of the scheduler.
// ---------------------------------------------------------------------------
package mfrq_pkg;

  localparam int ID_W    = 8;
  localparam int QUANT_W = 17;
  localparam int LVL_W   = 2;
  localparam int IDX_W   = 3;

  // Handles are kept modulo the handle count, a power of two.
  localparam int            ID_COUNT = 256;
  localparam logic [ID_W-1:0] ID_MASK = ID_W'(ID_COUNT - 1);

  localparam int FIFO_COUNT = 4;

  localparam logic [LVL_W-1:0] LVL_HIGH = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MED  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_LOW  = 2'd2;
  localparam logic [LVL_W-1:0] LVL_RR   = 2'd3;

  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_GET = 1'b1;

  localparam logic MODE_RR = 1'b0;
  localparam logic MODE_FB = 1'b1;

  localparam logic [IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_RR_Q   = 3'd1;
  localparam logic [IDX_W-1:0] CFG_HIGH_Q = 3'd2;
  localparam logic [IDX_W-1:0] CFG_MED_Q  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_LOW_Q  = 3'd4;

  localparam logic               MODE_RESET   = MODE_RR;
  localparam logic [QUANT_W-1:0] RR_Q_RESET   = 17'd8192;
  localparam logic [QUANT_W-1:0] HIGH_Q_RESET = 17'd8192;
  localparam logic [QUANT_W-1:0] MED_Q_RESET  = 17'd65536;
  localparam logic [QUANT_W-1:0] LOW_Q_RESET  = 17'd65536;

  // One pointer update request for the selected FIFO.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [LVL_W-1:0] q;
  } ptr_op_t;

endpackage

// ===== hw/rtl/mfrq_in_if.sv =====
// ---------------------------------------------------------------------------
// Request input channel
// Valid/ready channel carrying one add or get word.
// ---------------------------------------------------------------------------
interface mfrq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [mfrq_pkg::ID_W-1:0]    request_id;
  logic [mfrq_pkg::QUANT_W-1:0] quantum_in;

  modport source (output valid, action, request_id, quantum_in, input ready);
  modport sink   (input valid, action, request_id, quantum_in, output ready);
endinterface

// ===== hw/rtl/mfrq_out_if.sv =====
// ---------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one result word per request word.
// ---------------------------------------------------------------------------
interface mfrq_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [mfrq_pkg::ID_W-1:0]    request_out;
  logic [mfrq_pkg::LVL_W-1:0]   level_out;
  logic [mfrq_pkg::QUANT_W-1:0] quantum_out;
  logic                         full_error;

  modport source (output valid, found, request_out, level_out, quantum_out, full_error,
                  input ready);
  modport sink   (input valid, found, request_out, level_out, quantum_out, full_error,
                  output ready);
endinterface

// ===== hw/rtl/mfrq_slot_ram.sv =====
// ---------------------------------------------------------------------------
// Slot memory
// Simple dual-port RAM holding the handles of all FIFOs, registered read.
// ---------------------------------------------------------------------------
module mfrq_slot_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/mfrq_ptr_file.sv =====
// ---------------------------------------------------------------------------
// FIFO pointer file
// Head, tail and fill count of each of the four FIFOs.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mfrq_ptr_file #(
  parameter int DEPTH = 64,
  parameter int PW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mfrq_pkg::ptr_op_t                 op,
  output logic [PW-1:0]                     head,
  output logic [PW-1:0]                     tail,
  output logic [mfrq_pkg::FIFO_COUNT-1:0]   nonempty,
  output logic [mfrq_pkg::FIFO_COUNT-1:0]   full
);

  localparam logic [PW-1:0] LAST_POS = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [PW-1:0] heads_r  [mfrq_pkg::FIFO_COUNT];
  logic [PW-1:0] tails_r  [mfrq_pkg::FIFO_COUNT];
  logic [CW-1:0] counts_r [mfrq_pkg::FIFO_COUNT];
  logic [PW-1:0] heads_nxt  [mfrq_pkg::FIFO_COUNT];
  logic [PW-1:0] tails_nxt  [mfrq_pkg::FIFO_COUNT];
  logic [CW-1:0] counts_nxt [mfrq_pkg::FIFO_COUNT];

  assign head = heads_r[op.q];
  assign tail = tails_r[op.q];

  always_comb begin
    for (int i = 0; i < mfrq_pkg::FIFO_COUNT; i++) begin
      nonempty[i] = (counts_r[i] != '0);
      full[i]     = (counts_r[i] == FULL_CNT);
    end
  end

  always_comb begin
    for (int i = 0; i < mfrq_pkg::FIFO_COUNT; i++) begin
      heads_nxt[i]  = heads_r[i];
      tails_nxt[i]  = tails_r[i];
      counts_nxt[i] = counts_r[i];
    end
    if (op.push) begin
      tails_nxt[op.q]  = (tails_r[op.q] == LAST_POS) ? '0 : tails_r[op.q] + 1'b1;
      counts_nxt[op.q] = counts_r[op.q] + 1'b1;
    end else if (op.pop) begin
      heads_nxt[op.q]  = (heads_r[op.q] == LAST_POS) ? '0 : heads_r[op.q] + 1'b1;
      counts_nxt[op.q] = counts_r[op.q] - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mfrq_pkg::FIFO_COUNT; i++) begin
        heads_r[i]  <= '0;
        tails_r[i]  <= '0;
        counts_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < mfrq_pkg::FIFO_COUNT; i++) begin
        heads_r[i]  <= heads_nxt[i];
        tails_r[i]  <= tails_nxt[i];
        counts_r[i] <= counts_nxt[i];
      end
    end
  end

  `ASSERT_NEVER(a_push_full, clk, rst_n, op.push && full[op.q])
  `ASSERT_NEVER(a_pop_empty, clk, rst_n, op.pop && !nonempty[op.q])
  `ASSERT_CLK(a_push_fills, clk, rst_n, op.push |=> nonempty[$past(op.q)])

endmodule

// ===== hw/rtl/multilevel_feedback_request_queue_top.sv =====
// ---------------------------------------------------------------------------
// Multilevel feedback request queue
// Request scheduler: one round-robin FIFO or three feedback levels.
// ---------------------------------------------------------------------------
// Timing: an add, or a get that finds every level empty, shows its result
// in the cycle after the word is taken; a popping get waits in READ for the
// registered read of the single slot memory port. Adds: one word per cycle
// while the output is not stalled; no new word is taken while in READ.
// Reset (synchronous, active low) empties all FIFOs and restores register
// defaults; the slot memory is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module multilevel_feedback_request_queue_top #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mfrq_pkg::IDX_W-1:0]     cfg_index,
  input  logic [mfrq_pkg::QUANT_W-1:0]   cfg_wdata,
  mfrq_in_if.sink                        in_ch,
  mfrq_out_if.source                     out_ch
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int AW = mfrq_pkg::LVL_W + PW;

  // Control sequencer: IDLE takes words, READ waits for the slot memory.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic                         mode_r;
  logic [mfrq_pkg::QUANT_W-1:0] rr_q_r, high_q_r, med_q_r, low_q_r;

  // Result register; while a result waits, a new word is taken only if that result leaves.
  logic                         out_valid_r, out_valid_nxt;
  logic                         found_r, found_nxt;
  logic [mfrq_pkg::ID_W-1:0]    req_r, req_nxt;
  logic [mfrq_pkg::LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [mfrq_pkg::QUANT_W-1:0] quant_r, quant_nxt;
  logic                         full_err_r, full_err_nxt;
  logic [mfrq_pkg::LVL_W-1:0]   pend_lvl_r, pend_lvl_nxt;

  logic                         in_ready;
  logic                         in_fire;
  logic                         is_add;
  logic [mfrq_pkg::ID_W-1:0]    id_m;
  logic [mfrq_pkg::LVL_W-1:0]   add_lvl;
  logic [mfrq_pkg::LVL_W-1:0]   get_lvl;
  logic                         get_found;
  logic [mfrq_pkg::LVL_W-1:0]   sel_q;
  logic [mfrq_pkg::LVL_W-1:0]   quant_lvl;
  logic [mfrq_pkg::QUANT_W-1:0] lvl_quant;
  logic                         sel_full;

  mfrq_pkg::ptr_op_t                ptr_op;
  logic [PW-1:0]                    head, tail;
  logic [mfrq_pkg::FIFO_COUNT-1:0]  nonempty, full;
  logic [mfrq_pkg::ID_W-1:0]        rd_data;

  // A word is taken only in IDLE and only if the result register will be
  // free at the next edge.
  assign in_ready     = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = in_ready;
  assign in_fire      = in_ch.valid && in_ready;
  assign is_add       = (in_ch.action == mfrq_pkg::ACT_ADD);
  assign id_m         = in_ch.request_id & mfrq_pkg::ID_MASK;

  // Level chosen for an add: the zero-quantum test has priority over the
  // comparison against the high-level quantum.
  always_comb begin
    if (mode_r == mfrq_pkg::MODE_RR) begin
      add_lvl = mfrq_pkg::LVL_RR;
    end else if (in_ch.quantum_in == '0) begin
      add_lvl = mfrq_pkg::LVL_HIGH;
    end else if (in_ch.quantum_in == high_q_r) begin
      add_lvl = mfrq_pkg::LVL_MED;
    end else begin
      add_lvl = mfrq_pkg::LVL_LOW;
    end
  end

  // A get pops the highest nonempty level of the current mode only; the
  // FIFOs of the other mode keep their words until that mode returns.
  always_comb begin
    get_found = 1'b0;
    get_lvl   = mfrq_pkg::LVL_HIGH;
    if (mode_r == mfrq_pkg::MODE_RR) begin
      get_found = nonempty[mfrq_pkg::LVL_RR];
      get_lvl   = mfrq_pkg::LVL_RR;
    end else if (nonempty[mfrq_pkg::LVL_HIGH]) begin
      get_found = 1'b1;
      get_lvl   = mfrq_pkg::LVL_HIGH;
    end else if (nonempty[mfrq_pkg::LVL_MED]) begin
      get_found = 1'b1;
      get_lvl   = mfrq_pkg::LVL_MED;
    end else if (nonempty[mfrq_pkg::LVL_LOW]) begin
      get_found = 1'b1;
      get_lvl   = mfrq_pkg::LVL_LOW;
    end
  end

  assign sel_q    = is_add ? add_lvl : get_lvl;
  assign sel_full = full[sel_q];

  assign ptr_op.q    = sel_q;
  assign ptr_op.push = in_fire && is_add && !sel_full;
  assign ptr_op.pop  = in_fire && !is_add && get_found;

  // The quantum is looked up once: for the popped level while a read is in
  // flight, otherwise for the level of the add.
  assign quant_lvl = (state_r == ST_READ) ? pend_lvl_r : add_lvl;

  always_comb begin
    case (quant_lvl)
      mfrq_pkg::LVL_HIGH: lvl_quant = high_q_r;
      mfrq_pkg::LVL_MED:  lvl_quant = med_q_r;
      mfrq_pkg::LVL_LOW:  lvl_quant = low_q_r;
      default:            lvl_quant = rr_q_r;
    endcase
  end

  mfrq_ptr_file #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ptr (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (ptr_op),
    .head     (head),
    .tail     (tail),
    .nonempty (nonempty),
    .full     (full)
  );

  // Each FIFO owns a block of slots addressed by its level and pointer. An
  // add writes at the edge that takes it, so any later get reads the new
  // handle; only one word is in flight, so no forwarding is needed.
  mfrq_slot_ram #(
    .AW (AW),
    .DW (mfrq_pkg::ID_W)
  ) u_ram (
    .clk   (clk),
    .we    (ptr_op.push),
    .waddr ({sel_q, tail}),
    .wdata (id_m),
    .re    (ptr_op.pop),
    .raddr ({sel_q, head}),
    .rdata (rd_data)
  );

  // Sequencer and result register.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    req_nxt       = req_r;
    lvl_nxt       = lvl_r;
    quant_nxt     = quant_r;
    full_err_nxt  = full_err_r;
    pend_lvl_nxt  = pend_lvl_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_add) begin
            out_valid_nxt = 1'b1;
            found_nxt     = !sel_full;
            req_nxt       = id_m;
            lvl_nxt       = add_lvl;
            quant_nxt     = sel_full ? '0 : lvl_quant;
            full_err_nxt  = sel_full;
          end else if (get_found) begin
            pend_lvl_nxt  = get_lvl;
            state_nxt     = ST_READ;
          end else begin
            out_valid_nxt = 1'b1;
            found_nxt     = 1'b0;
            req_nxt       = '0;
            lvl_nxt       = mfrq_pkg::LVL_HIGH;
            quant_nxt     = '0;
            full_err_nxt  = 1'b0;
          end
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        found_nxt     = 1'b1;
        req_nxt       = rd_data;
        lvl_nxt       = pend_lvl_r;
        quant_nxt     = lvl_quant;
        full_err_nxt  = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r    <= found_nxt;
    req_r      <= req_nxt;
    lvl_r      <= lvl_nxt;
    quant_r    <= quant_nxt;
    full_err_r <= full_err_nxt;
    pend_lvl_r <= pend_lvl_nxt;
  end

  // Configuration writes; an index beyond the register list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= mfrq_pkg::MODE_RESET;
      rr_q_r   <= mfrq_pkg::RR_Q_RESET;
      high_q_r <= mfrq_pkg::HIGH_Q_RESET;
      med_q_r  <= mfrq_pkg::MED_Q_RESET;
      low_q_r  <= mfrq_pkg::LOW_Q_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mfrq_pkg::CFG_MODE:   mode_r   <= cfg_wdata[0];
        mfrq_pkg::CFG_RR_Q:   rr_q_r   <= cfg_wdata;
        mfrq_pkg::CFG_HIGH_Q: high_q_r <= cfg_wdata;
        mfrq_pkg::CFG_MED_Q:  med_q_r  <= cfg_wdata;
        mfrq_pkg::CFG_LOW_Q:  low_q_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = found_r;
  assign out_ch.request_out = req_r;
  assign out_ch.level_out   = lvl_r;
  assign out_ch.quantum_out = quant_r;
  assign out_ch.full_error  = full_err_r;

  // The memory read result must always find the result register empty.
  `ASSERT_CLK(a_read_slot_free, clk, rst_n, (state_r == ST_READ) |-> !out_valid_r)
  // A popping get moves the sequencer to READ to wait for the memory.
  `ASSERT_CLK(a_pop_reads, clk, rst_n, ptr_op.pop |=> (state_r == ST_READ))
  `ASSERT_NEVER(a_no_take_in_read, clk, rst_n, (state_r == ST_READ) && in_ready)

endmodule
